// ----- hw/rtl/adaf_pkg.sv -----
`default_nettype none

package adaf_pkg;

   localparam int REQ_DATA_W = 16;
   localparam int SAMPLE_W   = 12;
   localparam int DIST_W     = 12;
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 3;

   localparam logic [9:0] SCALE_NUM   = 10'd675;
   localparam int         SCALE_SHIFT = 10;

   localparam logic [BYTE_W-1:0] CH_STX  = 8'h02;
   localparam logic [BYTE_W-1:0] CH_DOT  = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ETX  = 8'h03;
   localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

   localparam logic [POS_W-1:0] POS_STX  = 3'd0;
   localparam logic [POS_W-1:0] POS_THOU = 3'd1;
   localparam logic [POS_W-1:0] POS_DOT  = 3'd2;
   localparam logic [POS_W-1:0] POS_HUN  = 3'd3;
   localparam logic [POS_W-1:0] POS_TEN  = 3'd4;
   localparam logic [POS_W-1:0] POS_ONE  = 3'd5;
   localparam logic [POS_W-1:0] POS_CR   = 3'd6;
   localparam logic [POS_W-1:0] POS_ETX  = 3'd7;

endpackage

`default_nettype wire

// ----- hw/rtl/adc_distance_ascii_framer_unit.sv -----
// Converts a 12-bit ADC sample into a distance, floor(sample * 675 / 1024) in
// thousandths of a cm, and sends it as an 8-byte ASCII frame: STX, thousands
// digit, '.', hundreds, tens and units digits, CR and ETX.
// The req channel carries one sample per transaction in req_tdata[11:0].
// The rsp channel carries one frame byte per transaction in rsp_tdata, with
// rsp_tlast high on the ETX byte.
// A sample passes four register stages (scale, thousands digit, hundreds
// digit, tens and units digits) in that order, and its STX byte is offered
// from the last of them.
// The frame register sends one byte per cycle while the receiver is ready. The
// stages keep taking samples while a frame is being sent, until every stage
// holds one.
// When the receiver stalls, the current byte holds and the stages behind it
// fill up and then hold; no sample or byte is lost or repeated.
// A synchronous reset empties all stages and drops rsp_tvalid.
`default_nettype none

module adc_distance_ascii_framer_unit
   import adaf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] sample
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [BYTE_W-1:0]          rsp_tdata,   // [7:0] tx_byte
   output logic                       rsp_tlast    // frame_end
);

   logic                s1_v_ff, s1_v_in;
   logic [DIST_W-1:0]   s1_dist_ff, s1_dist_in;
   logic [21:0]         s1_prod;

   logic                s2_v_ff, s2_v_in;
   logic [1:0]          s2_thou_ff, s2_thou_in;
   logic [9:0]          s2_rem_ff, s2_rem_in;

   logic                s3_v_ff, s3_v_in;
   logic [1:0]          s3_thou_ff, s3_thou_in;
   logic [3:0]          s3_hun_ff, s3_hun_in;
   logic [6:0]          s3_rem_ff, s3_rem_in;
   logic [15:0]         s3_hmul;
   logic [9:0]          s3_h100;

   logic                fr_v_ff, fr_v_in;
   logic [POS_W-1:0]    fr_pos_ff, fr_pos_in;
   logic [1:0]          fr_thou_ff, fr_thou_in;
   logic [3:0]          fr_hun_ff, fr_hun_in;
   logic [3:0]          fr_ten_ff, fr_ten_in;
   logic [3:0]          fr_one_ff, fr_one_in;
   logic [13:0]         fr_tmul;
   logic [6:0]          fr_t10;

   logic                rsp_hs, fr_done, fr_rdy, s3_rdy, s2_rdy, s1_rdy;

   assign rsp_hs  = rsp_tvalid & rsp_tready;
   assign fr_done = rsp_hs & (fr_pos_ff == POS_ETX);
   assign fr_rdy  = ~fr_v_ff | fr_done;
   assign s3_rdy  = ~s3_v_ff | fr_rdy;
   assign s2_rdy  = ~s2_v_ff | s3_rdy;
   assign s1_rdy  = ~s1_v_ff | s2_rdy;

   assign req_tready = s1_rdy;

   always_comb begin
      s1_prod    = 22'(req_tdata[SAMPLE_W-1:0]) * 22'(SCALE_NUM);
      s1_v_in    = s1_rdy ? req_tvalid : s1_v_ff;
      s1_dist_in = s1_rdy ? s1_prod[SCALE_SHIFT +: DIST_W] : s1_dist_ff;
   end

   always_comb begin
      s2_v_in    = s2_rdy ? s1_v_ff : s2_v_ff;
      s2_thou_in = s2_thou_ff;
      s2_rem_in  = s2_rem_ff;
      if (s2_rdy) begin
         if (s1_dist_ff >= 12'd2000) begin
            s2_thou_in = 2'd2;
            s2_rem_in  = 10'(s1_dist_ff - 12'd2000);
         end else if (s1_dist_ff >= 12'd1000) begin
            s2_thou_in = 2'd1;
            s2_rem_in  = 10'(s1_dist_ff - 12'd1000);
         end else begin
            s2_thou_in = 2'd0;
            s2_rem_in  = s1_dist_ff[9:0];
         end
      end
   end

   always_comb begin
      s3_hmul    = 16'(s2_rem_ff) * 16'd41;
      s3_h100    = 10'(s3_hmul[15:12]) * 10'd100;
      s3_v_in    = s3_rdy ? s2_v_ff : s3_v_ff;
      s3_thou_in = s3_rdy ? s2_thou_ff : s3_thou_ff;
      s3_hun_in  = s3_rdy ? s3_hmul[15:12] : s3_hun_ff;
      s3_rem_in  = s3_rdy ? 7'(s2_rem_ff - s3_h100) : s3_rem_ff;
   end

   always_comb begin
      fr_tmul    = 14'(s3_rem_ff) * 14'd103;
      fr_t10     = 7'(fr_tmul[13:10]) * 7'd10;
      fr_v_in    = fr_v_ff;
      fr_pos_in  = fr_pos_ff;
      fr_thou_in = fr_thou_ff;
      fr_hun_in  = fr_hun_ff;
      fr_ten_in  = fr_ten_ff;
      fr_one_in  = fr_one_ff;
      if (fr_rdy) begin
         fr_v_in    = s3_v_ff;
         fr_pos_in  = POS_STX;
         fr_thou_in = s3_thou_ff;
         fr_hun_in  = s3_hun_ff;
         fr_ten_in  = fr_tmul[13:10];
         fr_one_in  = 4'(s3_rem_ff - fr_t10);
      end else if (rsp_hs) begin
         fr_pos_in  = fr_pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         fr_v_ff   <= 1'b0;
         fr_pos_ff <= POS_STX;
      end else begin
         s1_v_ff   <= s1_v_in;
         s2_v_ff   <= s2_v_in;
         s3_v_ff   <= s3_v_in;
         fr_v_ff   <= fr_v_in;
         fr_pos_ff <= fr_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dist_ff <= s1_dist_in;
      s2_thou_ff <= s2_thou_in;
      s2_rem_ff  <= s2_rem_in;
      s3_thou_ff <= s3_thou_in;
      s3_hun_ff  <= s3_hun_in;
      s3_rem_ff  <= s3_rem_in;
      fr_thou_ff <= fr_thou_in;
      fr_hun_ff  <= fr_hun_in;
      fr_ten_ff  <= fr_ten_in;
      fr_one_ff  <= fr_one_in;
   end

   always_comb begin
      case (fr_pos_ff)
         POS_STX:  rsp_tdata = CH_STX;
         POS_THOU: rsp_tdata = CH_ZERO | BYTE_W'(fr_thou_ff);
         POS_DOT:  rsp_tdata = CH_DOT;
         POS_HUN:  rsp_tdata = CH_ZERO | BYTE_W'(fr_hun_ff);
         POS_TEN:  rsp_tdata = CH_ZERO | BYTE_W'(fr_ten_ff);
         POS_ONE:  rsp_tdata = CH_ZERO | BYTE_W'(fr_one_ff);
         POS_CR:   rsp_tdata = CH_CR;
         POS_ETX:  rsp_tdata = CH_ETX;
         default:  rsp_tdata = CH_ETX;
      endcase
   end

   assign rsp_tvalid = fr_v_ff;
   assign rsp_tlast  = (fr_pos_ff == POS_ETX);

endmodule

`default_nettype wire

// ----- hw/rtl/adaf_checker.sv -----
`default_nettype none

module adaf_checker
   import adaf_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [BYTE_W-1:0]     rsp_tdata,
   input wire logic                  rsp_tlast
);

   logic req_hs;
   logic rsp_hs;

   assign req_hs = req_tvalid & req_tready;
   assign rsp_hs = rsp_tvalid & rsp_tready;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled rsp transaction changed");

   a_last_is_etx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata == CH_ETX)))
      else $error("rsp_tlast does not match the ETX byte");

   a_frame_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_hs && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a frame");

   a_thou_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_hs && (rsp_tdata == CH_STX) && !req_hs) |=>
         ((rsp_tdata >= CH_ZERO) && (rsp_tdata <= (CH_ZERO + 8'd2))))
      else $error("thousands digit out of range");

endmodule

bind adc_distance_ascii_framer_unit adaf_checker u_adaf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import adaf_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              frame_end;
   } frame_byte_type;

   // A row either carries the four distance digits typed in, or leaves them to
   // the predictor.
   typedef struct packed {
      logic [REQ_DATA_W-1:0] data;
      logic                  typed;
      logic [31:0]           digits;
   } sample_row_type;

   localparam int NUM_DIRECTED = 18;
   localparam int NUM_RANDOM   = 92;

   localparam sample_row_type DIRECTED_SAMPLES [NUM_DIRECTED] = '{
      '{16'h0000, 1'b1, "0000"},
      '{16'h0FFF, 1'b1, "2699"},
      '{16'hF000, 1'b1, "0000"},
      '{16'hFFFF, 1'b1, "2699"},
      '{16'h0001, 1'b1, "0000"},
      '{16'h0002, 1'b1, "0001"},
      '{16'h0400, 1'b1, "0675"},
      '{16'h0800, 1'b1, "1350"},
      '{16'h05ED, 1'b0, 32'h0},
      '{16'h05EE, 1'b0, 32'h0},
      '{16'h0AAA, 1'b0, 32'h0},
      '{16'h0555, 1'b0, 32'h0},
      '{16'h8123, 1'b0, 32'h0},
      '{16'h7FFF, 1'b0, 32'h0},
      '{16'h0010, 1'b0, 32'h0},
      '{16'h00F0, 1'b0, 32'h0},
      '{16'h0F0F, 1'b0, 32'h0},
      '{16'h3C00, 1'b0, 32'h0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;

   frame_byte_type pending_bytes[$];
   int             mismatch_count = 0;
   bit             steady_sender = 1'b0;

   adc_distance_ascii_framer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [31:0] distance_digits(input logic [SAMPLE_W-1:0] sample);
      int unsigned scaled;
      logic [31:0] digits;
      scaled = (int'(sample) * int'(SCALE_NUM)) >> SCALE_SHIFT;
      digits[31:24] = CH_ZERO + BYTE_W'((scaled / 1000) % 10);
      digits[23:16] = CH_ZERO + BYTE_W'((scaled / 100) % 10);
      digits[15:8]  = CH_ZERO + BYTE_W'((scaled / 10) % 10);
      digits[7:0]   = CH_ZERO + BYTE_W'(scaled % 10);
      return digits;
   endfunction

   function automatic void push_frame(input logic [31:0] digits);
      pending_bytes.push_back('{CH_STX, 1'b0});
      pending_bytes.push_back('{digits[31:24], 1'b0});
      pending_bytes.push_back('{CH_DOT, 1'b0});
      pending_bytes.push_back('{digits[23:16], 1'b0});
      pending_bytes.push_back('{digits[15:8], 1'b0});
      pending_bytes.push_back('{digits[7:0], 1'b0});
      pending_bytes.push_back('{CH_CR, 1'b0});
      pending_bytes.push_back('{CH_ETX, 1'b1});
   endfunction

   // The frame is queued at the edge where the sample transaction completes.
   task automatic send_sample(input logic [REQ_DATA_W-1:0] data, input logic typed,
                              input logic [31:0] digits);
      while (!steady_sender && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      push_frame(typed ? digits : distance_digits(data[SAMPLE_W-1:0]));
   endtask

   initial begin
      logic [REQ_DATA_W-1:0] data;
      int                    pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED_SAMPLES[i])
         send_sample(DIRECTED_SAMPLES[i].data, DIRECTED_SAMPLES[i].typed,
                     DIRECTED_SAMPLES[i].digits);
      for (int n = 0; n < NUM_RANDOM; n++) begin
         steady_sender = (n >= 40 && n < 75);
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            data = REQ_DATA_W'($urandom);
         end else if (pick == 3) begin
            data = REQ_DATA_W'($urandom_range(0, 15));
         end else if (pick == 4) begin
            data = REQ_DATA_W'($urandom_range(4080, 4095));
         end else begin
            data = REQ_DATA_W'($urandom_range(0, 4095));
         end
         send_sample(data, 1'b0, 32'h0);
      end
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // The receiver holds off for a long stretch early on so that the block
   // backs up into req_tready, and later stays ready for a while.
   initial begin
      int cycle;
      cycle = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle >= 200 && cycle < 290) begin
            rsp_tready <= 1'b0;
         end else if (cycle >= 600 && cycle < 1000) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 13);
         end
      end
   end

   always @(posedge clock) begin
      frame_byte_type exp_byte;
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_bytes.size() == 0) begin
            $error("rsp transaction with no frame byte pending: tx_byte %h", rsp_tdata);
            mismatch_count++;
         end else begin
            exp_byte = pending_bytes.pop_front();
            if (rsp_tdata !== exp_byte.tx_byte) begin
               $error("tx_byte: expected %h, actual %h", exp_byte.tx_byte, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== exp_byte.frame_end) begin
               $error("frame_end: expected %b, actual %b", exp_byte.frame_end, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

endmodule

// ----- sim.f -----
hw/rtl/adaf_pkg.sv
hw/rtl/adc_distance_ascii_framer_unit.sv
hw/rtl/adaf_checker.sv
verif/tb_top.sv
